[hw/rtl/dmh_pkg.sv]
// Shared types, codes and command/status structs of the deadline timer queue.
package dmh_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int NW          = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_FIRED    = 2'd2
    } kind_t;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] handle;
        logic [31:0] delay_ticks;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] out_handle;
        logic [63:0] fire_time;
        logic        last;
    } out_t;

    typedef struct packed {
        logic load;        // latch accepted request
        logic push_sched;  // emit schedule answer
        logic up_init;     // start sift-up at the tail
        logic rd_parent;
        logic wr_item;     // place held entry at pos
        logic wr_up;       // move parent down to pos, climb
        logic rd_root;
        logic pop;         // retire root, read tail entry
        logic load_item;   // held entry from read data
        logic rd_children;
        logic wr_dn;       // move chosen child up to pos, descend
        logic push_flush;  // emit held result as last
    } cmd_t;

    typedef struct packed {
        logic in_tick;
        logic full;
        logic pos_zero;
        logic item_lt_parent;
        logic cnt_zero;
        logic n_max;
        logic root_due;
        logic pend_valid;
        logic out_free;
        logic left_out;
        logic item_le_child;
    } status_t;

endpackage

[hw/rtl/deadline_min_heap_timer_queue.sv]
// Top level of the deadline timer queue: binary min-heap on fire time.
//
//  channel | ports                      | payload
//  --------+----------------------------+------------------------------------
//  input   | s_valid s_ready s_data     | cmd, handle, delay_ticks
//  result  | m_valid m_ready m_data     | kind, out_handle, fire_time, last
//
// A schedule answers, then climbs one heap level per parent read and compare;
// a tick pops the root while it is due, up to MAX_RESULTS, moving the tail
// entry to the root and sinking it, then emits the held result as last.
// Each level costs one registered read of the heap memory and one compare.
// Reset clears the entry count and the time; heap contents are left as is.
// New requests wait while a tick or sift is running; a held result stalls pops.
module deadline_min_heap_timer_queue #(
    parameter int CAPACITY    = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dmh_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output dmh_pkg::out_t  m_data
);
    import dmh_pkg::*;

    cmd_t    cmd;
    status_t st;

    dmh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    dmh_data #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_data (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .st      (st)
    );

endmodule

[hw/rtl/dmh_ctrl.sv]
// Sequencer for insert sift-up, pop loop and sift-down of the timer heap.
module dmh_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  dmh_pkg::status_t st,
    output dmh_pkg::cmd_t    cmd
);
    import dmh_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_SCHED    = 10'b0000000010,
        ST_UP_TEST  = 10'b0000000100,
        ST_UP_CMP   = 10'b0000001000,
        ST_POP_TEST = 10'b0000010000,
        ST_POP_CMP  = 10'b0000100000,
        ST_DN_LOAD  = 10'b0001000000,
        ST_DN_RD    = 10'b0010000000,
        ST_DN_CMP   = 10'b0100000000,
        ST_FLUSH    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = st.in_tick ? ST_POP_TEST : ST_SCHED;
                end
            end
            ST_SCHED: begin
                if (st.out_free) begin
                    cmd.push_sched = 1'b1;
                    if (st.full) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.up_init = 1'b1;
                        state_next  = ST_UP_TEST;
                    end
                end
            end
            ST_UP_TEST: begin
                if (st.pos_zero) begin
                    cmd.wr_item = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.rd_parent = 1'b1;
                    state_next    = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (st.item_lt_parent) begin
                    cmd.wr_up  = 1'b1;
                    state_next = ST_UP_TEST;
                end else begin
                    cmd.wr_item = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_POP_TEST: begin
                if (st.cnt_zero || st.n_max) begin
                    state_next = ST_FLUSH;
                end else begin
                    cmd.rd_root = 1'b1;
                    state_next  = ST_POP_CMP;
                end
            end
            ST_POP_CMP: begin
                if (!st.root_due) begin
                    state_next = ST_FLUSH;
                end else if (!st.pend_valid || st.out_free) begin
                    cmd.pop    = 1'b1;
                    // count drops by one; tail read is only useful if any remain
                    state_next = st.cnt_zero ? ST_POP_TEST : ST_DN_LOAD;
                end
            end
            ST_DN_LOAD: begin
                cmd.load_item = 1'b1;
                state_next    = ST_DN_RD;
            end
            ST_DN_RD: begin
                if (st.left_out) begin
                    cmd.wr_item = 1'b1;
                    state_next  = ST_POP_TEST;
                end else begin
                    cmd.rd_children = 1'b1;
                    state_next      = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                if (st.item_le_child) begin
                    cmd.wr_item = 1'b1;
                    state_next  = ST_POP_TEST;
                end else begin
                    cmd.wr_dn  = 1'b1;
                    state_next = ST_DN_RD;
                end
            end
            ST_FLUSH: begin
                if (!st.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (st.out_free) begin
                    cmd.push_flush = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/dmh_data.sv]
// Heap memory, time counter, held entry and result register of the timer queue.
module dmh_data #(
    parameter int CAPACITY    = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  dmh_pkg::in_t     s_data,
    output dmh_pkg::out_t    m_data,
    output logic             m_valid,
    input  logic             m_ready,
    input  dmh_pkg::cmd_t    cmd,
    output dmh_pkg::status_t st
);
    import dmh_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = IW + 2;
    localparam int HB = HANDLE_BITS;

    logic [HB-1:0] mem_h [CAPACITY];
    logic [63:0]   mem_t [CAPACITY];

    logic [CW-1:0] count_reg;
    logic [63:0]   time_reg;
    logic [NW-1:0] n_reg;
    logic [IW-1:0] pos_reg;
    logic [HB-1:0] item_h_reg;
    logic [63:0]   item_t_reg;
    logic [HB-1:0] rd0_h_reg, rd1_h_reg;
    logic [63:0]   rd0_t_reg, rd1_t_reg;
    logic          pend_valid_reg;
    logic [HB-1:0] pend_h_reg;
    logic [63:0]   pend_t_reg;
    out_t          out_reg;
    logic          out_valid_reg;

    logic [31:0]   in_h32;
    logic [IW-1:0] parent;
    logic [LW-1:0] left_idx, right_idx, count_ext;
    logic          pick_right;
    logic [HB-1:0] child_h;
    logic [63:0]   child_t;
    logic [IW-1:0] child_idx;
    logic [CW-1:0] count_dec;
    logic          out_free;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [HB-1:0] wr_h;
    logic [63:0]   wr_t;
    logic          rd_en;
    logic [IW-1:0] rd0_addr, rd1_addr;

    assign in_h32    = {16'b0, s_data.handle};
    assign parent    = (pos_reg - IW'(1)) >> 1;
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + LW'(1);
    assign count_ext = LW'(count_reg);
    assign count_dec = count_reg - CW'(1);
    assign pick_right = (right_idx < count_ext) && (rd1_t_reg < rd0_t_reg);
    assign child_h   = pick_right ? rd1_h_reg : rd0_h_reg;
    assign child_t   = pick_right ? rd1_t_reg : rd0_t_reg;
    assign child_idx = pick_right ? right_idx[IW-1:0] : left_idx[IW-1:0];
    assign out_free  = !out_valid_reg || m_ready;

    always_comb begin
        wr_en   = cmd.wr_item || cmd.wr_up || cmd.wr_dn;
        wr_addr = pos_reg;
        wr_h    = item_h_reg;
        wr_t    = item_t_reg;
        if (cmd.wr_up) begin
            wr_h = rd0_h_reg;
            wr_t = rd0_t_reg;
        end else if (cmd.wr_dn) begin
            wr_h = child_h;
            wr_t = child_t;
        end
        rd_en    = cmd.rd_parent || cmd.rd_root || cmd.pop || cmd.rd_children;
        rd0_addr = '0;
        rd1_addr = right_idx[IW-1:0];
        if (cmd.rd_parent) begin
            rd0_addr = parent;
        end else if (cmd.pop) begin
            rd0_addr = count_dec[IW-1:0];
        end else if (cmd.rd_children) begin
            rd0_addr = left_idx[IW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_h[wr_addr] <= wr_h;
            mem_t[wr_addr] <= wr_t;
        end
        if (rd_en) begin
            rd0_h_reg <= mem_h[rd0_addr];
            rd0_t_reg <= mem_t[rd0_addr];
            rd1_h_reg <= mem_h[rd1_addr];
            rd1_t_reg <= mem_t[rd1_addr];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_h_reg <= in_h32[HB-1:0];
            item_t_reg <= time_reg + {32'b0, s_data.delay_ticks};
        end else if (cmd.load_item) begin
            item_h_reg <= rd0_h_reg;
            item_t_reg <= rd0_t_reg;
        end
        if (cmd.up_init) begin
            pos_reg <= count_reg[IW-1:0];
        end else if (cmd.wr_up) begin
            pos_reg <= parent;
        end else if (cmd.wr_dn) begin
            pos_reg <= child_idx;
        end else if (cmd.load_item) begin
            pos_reg <= '0;
        end
        if (cmd.pop) begin
            pend_h_reg <= rd0_h_reg;
            pend_t_reg <= rd0_t_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            time_reg       <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load && s_data.cmd == CMD_TICK) begin
                time_reg <= time_reg + 64'd1;
                n_reg    <= '0;
            end
            if (cmd.up_init) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.pop) begin
                count_reg <= count_dec;
                n_reg     <= n_reg + NW'(1);
            end
            if (cmd.pop) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.push_flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.push_sched || cmd.push_flush || (cmd.pop && pend_valid_reg)) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic [31:0] item_h32, pend_h32;
    assign item_h32 = 32'(item_h_reg);
    assign pend_h32 = 32'(pend_h_reg);

    always_ff @(posedge aclk) begin
        if (cmd.push_sched) begin
            out_reg.kind       <= (count_reg == CW'(CAPACITY)) ? KIND_REJECTED
                                                                : KIND_ACCEPTED;
            out_reg.out_handle <= item_h32[15:0];
            out_reg.fire_time  <= item_t_reg;
            out_reg.last       <= 1'b1;
        end else if (cmd.push_flush || (cmd.pop && pend_valid_reg)) begin
            out_reg.kind       <= KIND_FIRED;
            out_reg.out_handle <= pend_h32[15:0];
            out_reg.fire_time  <= pend_t_reg;
            out_reg.last       <= cmd.push_flush;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

    always_comb begin
        st                = '0;
        st.in_tick        = s_data.cmd;
        st.full           = (count_reg == CW'(CAPACITY));
        st.pos_zero       = (pos_reg == '0);
        st.item_lt_parent = (item_t_reg < rd0_t_reg);
        // after a pop this reads the count left behind
        st.cnt_zero       = cmd.pop ? (count_dec == '0) : (count_reg == '0);
        st.n_max          = (n_reg == NW'(MAX_RESULTS));
        st.root_due       = (rd0_t_reg <= time_reg);
        st.pend_valid     = pend_valid_reg;
        st.out_free       = out_free;
        st.left_out       = (left_idx >= count_ext);
        st.item_le_child  = (item_t_reg <= child_t);
    end

endmodule

[tb/deadline_min_heap_timer_queue_tb.sv]
// Testbench for the deadline timer queue: heap predictor, random stimulus, result checks.
`timescale 1ns / 1ps

module deadline_min_heap_timer_queue_tb;
    import dmh_pkg::*;

    localparam int CAP       = 64;
    localparam int MAX_POPS  = 64;
    localparam longint CYCLE_LIMIT = 10000000;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;

    deadline_min_heap_timer_queue uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // predicted heap state
    logic [15:0] heap_handle [CAP];
    logic [63:0] heap_due [CAP];
    int          heap_count;
    logic [63:0] now_ticks;
    out_t        pending_results [$];

    int     error_count = 0;
    longint cycle_count = 0;
    bit     quiet_tail = 0;
    int     stall_left = 0;

    function automatic void swap_entries(int a, int b);
        logic [15:0] h;
        logic [63:0] t;
        h = heap_handle[a]; t = heap_due[a];
        heap_handle[a] = heap_handle[b]; heap_due[a] = heap_due[b];
        heap_handle[b] = h; heap_due[b] = t;
    endfunction

    function automatic void sift_down_root();
        int pos;
        int l;
        int m;
        pos = 0;
        while (1) begin
            l = 2 * pos + 1;
            if (l >= heap_count) break;
            m = l;
            if (l + 1 < heap_count && heap_due[l + 1] < heap_due[l]) m = l + 1;
            if (heap_due[pos] <= heap_due[m]) break;
            swap_entries(pos, m);
            pos = m;
        end
    endfunction

    function automatic void predict_request(in_t req);
        out_t r;
        int pos;
        int n;
        if (req.cmd == CMD_SCHEDULE) begin
            r.out_handle = req.handle;
            r.fire_time  = now_ticks + {32'd0, req.delay_ticks};
            r.last       = 1'b1;
            if (heap_count >= CAP) begin
                r.kind = KIND_REJECTED;
            end else begin
                r.kind = KIND_ACCEPTED;
                heap_handle[heap_count] = req.handle;
                heap_due[heap_count] = r.fire_time;
                pos = heap_count;
                heap_count++;
                while (pos > 0 && heap_due[pos] < heap_due[(pos - 1) / 2]) begin
                    swap_entries(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
            end
            pending_results.push_back(r);
        end else begin
            now_ticks = now_ticks + 64'd1;
            n = 0;
            while (n < MAX_POPS && heap_count > 0 && heap_due[0] <= now_ticks) begin
                r.kind = KIND_FIRED;
                r.out_handle = heap_handle[0];
                r.fire_time = heap_due[0];
                r.last = 1'b0;
                pending_results.push_back(r);
                n++;
                heap_count--;
                if (heap_count > 0) begin
                    heap_handle[0] = heap_handle[heap_count];
                    heap_due[0] = heap_due[heap_count];
                    sift_down_root();
                end
            end
            if (n > 0) pending_results[$].last = 1'b1;
        end
    endfunction

    // drop valid only when a gap is taken
    task automatic idle_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic send_request(logic cmd, logic [15:0] h, logic [31:0] d);
        in_t req;
        idle_gap();
        req.cmd = cmd; req.handle = h; req.delay_ticks = d;
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(req);
    endtask

    task automatic schedule(logic [15:0] h, logic [31:0] d);
        send_request(CMD_SCHEDULE, h, d);
    endtask

    task automatic tick();
        send_request(CMD_TICK, 16'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // result side: stall bursts, compare each accepted result
    always @(posedge aclk) begin
        out_t exp_r;
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, m_data);
                    error_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (m_data.kind !== exp_r.kind || m_data.out_handle !== exp_r.out_handle
                        || m_data.fire_time !== exp_r.fire_time
                        || m_data.last !== exp_r.last) begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, exp_r, m_data);
                        error_count++;
                    end
                end
            end
            if (quiet_tail) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready    <= 1'b0;
                stall_left <= int'($urandom_range(0, 7));
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        schedule(16'h0000, 32'd0);          // due now, fires on next tick
        schedule(16'hFFFF, 32'hFFFF_FFFF);  // far future
        schedule(16'hA5A5, 32'd1);
        schedule(16'h5A5A, 32'd1);          // tie with previous
        schedule(16'h1234, 32'd2);
        tick();                              // several fire, tie order
        tick();
        tick();                              // idle tick
        wait_drained();
    endtask

    task automatic test_full_queue();
        int i;
        for (i = 0; i < CAP + 3; i++) schedule(i[15:0], $urandom_range(2, 40));
        // drain everything due; more than MAX_POPS can never be due at once here
        for (i = 0; i < 45; i++) tick();
        wait_drained();
    endtask

    task automatic test_mass_fire();
        int i;
        // fill with equal due times so one tick pops all of them
        for (i = 0; i < CAP; i++) schedule(16'($urandom), 32'd1);
        tick();
        wait_drained();
    endtask

    task automatic test_random(int count);
        int i;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 5)
                schedule(16'($urandom), ($urandom_range(0, 7) == 0) ? $urandom
                                                                    : $urandom_range(0, 30));
            else
                tick();
        end
    endtask

    initial begin
        now_ticks = '0;
        heap_count = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_queue();
        test_mass_fire();
        test_random(130);
        wait_drained();   // hold off the sender until all results arrive
        test_random(80);
        quiet_tail = 1;
        test_random(60);
        wait_drained();
        repeat (200) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
